[hw/rtl/oat_pkg.sv]
`default_nettype none

package oat_pkg;

    localparam int DEPTH_DEFAULT     = 64;
    localparam int WORD_BITS_DEFAULT = 32;
    localparam int ACTION_BITS       = 3;
    localparam int OPERAND_BITS      = 32;
    localparam int STATUS_BITS       = 2;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_APPEND  = 3'd0,
        ACT_INSERT  = 3'd1,
        ACT_PREPEND = 3'd2,
        ACT_POP     = 3'd3,
        ACT_DELETE  = 3'd4,
        ACT_REMOVE  = 3'd5,
        ACT_FIND    = 3'd6,
        ACT_READ    = 3'd7
    } action_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
    } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/ordered_array_table_engine_core.sv]
// Channel   Dir  Fields (tdata, lowest bit up)
// s_axis    in   action[2:0], position[9:3], operand_value[41:10]
// m_axis    out  status[1:0], read_value[33:2], found[34],
//                found_position[40:35], entry_count[47:41]
//
// Each item is accepted in S_IDLE, then run across the cell row in S_EXEC;
// no new item is taken until back in S_IDLE. Remove value repeats, and each
// match costs one compare pass of the cells and one shift-down of the row.
// rst_n clears the entry count and control; stored words stay undefined.
// A held result waits in the output register; a finished item behind it
// holds in its done state and input is refused until it moves on.
`default_nettype none

module ordered_array_table_engine_core #(
    parameter int DEPTH     = oat_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = oat_pkg::WORD_BITS_DEFAULT,
    localparam int POS_BITS = $clog2(DEPTH + 1),
    localparam int IDX_BITS = $clog2(DEPTH),
    localparam int S_FIELD_BITS = oat_pkg::ACTION_BITS + POS_BITS + oat_pkg::OPERAND_BITS,
    localparam int M_FIELD_BITS = oat_pkg::STATUS_BITS + oat_pkg::OPERAND_BITS + 1
                                  + IDX_BITS + POS_BITS,
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // action, position, operand_value
    input  logic [S_TDATA_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status, read_value, found, found_position, entry_count
    output logic [M_TDATA_BITS-1:0]  m_tdata
);
    import oat_pkg::*;

    localparam int POS_LO = ACTION_BITS;
    localparam int OPD_LO = ACTION_BITS + POS_BITS;
    localparam logic [POS_BITS-1:0] FULL_COUNT = POS_BITS'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_RCMP = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [POS_BITS-1:0]   count_reg, count_next;
    action_t               act_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [WORD_BITS-1:0]  w_reg;

    logic                  m_valid_reg, m_valid_next;
    status_t               o_status_reg;
    logic [OPERAND_BITS-1:0] o_rd_reg;
    logic                  o_found_reg;
    logic [IDX_BITS-1:0]   o_fpos_reg;
    logic [POS_BITS-1:0]   o_count_reg;

    status_t               p_status_reg;
    logic [OPERAND_BITS-1:0] p_rd_reg;
    logic                  p_found_reg;
    logic [IDX_BITS-1:0]   p_fpos_reg;
    logic [POS_BITS-1:0]   p_count_reg;

    status_t               res_status;
    logic signed [OPERAND_BITS-1:0] res_rd;
    logic                  res_found;
    logic [IDX_BITS-1:0]   res_fpos;
    logic                  res_done;

    logic                  in_acc;
    logic                  out_free;
    logic signed [OPERAND_BITS-1:0] s_operand;
    logic signed [WORD_BITS-1:0]    in_word;

    cell_ctl_t             ctl;
    logic [POS_BITS-1:0]   cell_pos;
    logic [WORD_BITS-1:0]  cell_cmp_word;

    logic [DEPTH-1:0][WORD_BITS-1:0] cell_data;
    logic [DEPTH-1:0]      cell_match;

    logic                  scan_any;
    logic [IDX_BITS-1:0]   scan_idx;
    logic signed [WORD_BITS-1:0] scan_rd;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_operand = s_tdata[OPD_LO +: OPERAND_BITS];
    assign in_word   = WORD_BITS'(s_operand);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic [WORD_BITS-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = w_reg;
        end
        else
        begin : g_inner_l
            assign left_word = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_word = cell_data[i];
        end
        else
        begin : g_inner_r
            assign right_word = cell_data[i+1];
        end

        oat_cell #(
            .DEPTH     (DEPTH),
            .WORD_BITS (WORD_BITS),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (cell_pos),
            .count      (count_reg),
            .cmp_word   (cell_cmp_word),
            .wr_word    (w_reg),
            .left_data  (left_word),
            .right_data (right_word),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    oat_scan #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .match     (cell_match),
        .cell_data (cell_data),
        .pos       (pos_reg),
        .any       (scan_any),
        .first_idx (scan_idx),
        .rd_word   (scan_rd)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ctl           = '{op: CELL_HOLD, cmp_en: 1'b0};
        cell_pos      = pos_reg;
        cell_cmp_word = w_reg;
        res_status    = STAT_OK;
        res_rd        = '0;
        res_found     = 1'b0;
        res_fpos      = '0;
        res_done      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    ctl.cmp_en    = 1'b1;
                    cell_cmp_word = in_word;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_done = 1'b1;
                case (act_reg)
                    ACT_APPEND:
                    begin
                        if (count_reg >= FULL_COUNT)
                        begin
                            res_status = STAT_FULL;
                        end
                        else
                        begin
                            ctl.op     = CELL_INSERT;
                            cell_pos   = count_reg;
                            count_next = count_reg + POS_BITS'(1);
                        end
                    end
                    ACT_INSERT:
                    begin
                        if (pos_reg > count_reg)
                        begin
                            res_status = STAT_RANGE;
                        end
                        else if (count_reg >= FULL_COUNT)
                        begin
                            res_status = STAT_FULL;
                        end
                        else
                        begin
                            ctl.op     = CELL_INSERT;
                            count_next = count_reg + POS_BITS'(1);
                        end
                    end
                    ACT_PREPEND:
                    begin
                        if (count_reg >= FULL_COUNT)
                        begin
                            res_status = STAT_FULL;
                        end
                        else
                        begin
                            ctl.op     = CELL_INSERT;
                            cell_pos   = '0;
                            count_next = count_reg + POS_BITS'(1);
                        end
                    end
                    ACT_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status = STAT_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - POS_BITS'(1);
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status = STAT_EMPTY;
                        end
                        else if (pos_reg >= count_reg)
                        begin
                            res_status = STAT_RANGE;
                        end
                        else
                        begin
                            ctl.op     = CELL_DELETE;
                            count_next = count_reg - POS_BITS'(1);
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (scan_any)
                        begin
                            ctl.op     = CELL_DELETE;
                            cell_pos   = POS_BITS'(scan_idx);
                            count_next = count_reg - POS_BITS'(1);
                            res_done   = 1'b0;
                            state_next = S_RCMP;
                        end
                    end
                    ACT_FIND:
                    begin
                        res_found = scan_any;
                        res_fpos  = scan_idx;
                    end
                    ACT_READ:
                    begin
                        if (pos_reg >= count_reg)
                        begin
                            res_status = STAT_RANGE;
                        end
                        else
                        begin
                            res_rd = OPERAND_BITS'(scan_rd);
                        end
                    end
                    default:
                    begin
                        res_done = 1'b1;
                    end
                endcase
                if (res_done)
                begin
                    state_next = out_free ? S_IDLE : S_DONE;
                end
            end
            S_RCMP:
            begin
                ctl.cmp_en = 1'b1;
                state_next = S_EXEC;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_free && ((state_reg == S_EXEC && res_done) || state_reg == S_DONE))
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg <= action_t'(s_tdata[ACTION_BITS-1:0]);
            pos_reg <= s_tdata[POS_LO +: POS_BITS];
            w_reg   <= in_word;
        end
        if (state_reg == S_EXEC && res_done)
        begin
            p_status_reg <= res_status;
            p_rd_reg     <= res_rd;
            p_found_reg  <= res_found;
            p_fpos_reg   <= res_fpos;
            p_count_reg  <= count_next;
        end
        if (out_free && state_reg == S_EXEC && res_done)
        begin
            o_status_reg <= res_status;
            o_rd_reg     <= res_rd;
            o_found_reg  <= res_found;
            o_fpos_reg   <= res_fpos;
            o_count_reg  <= count_next;
        end
        else if (out_free && state_reg == S_DONE)
        begin
            o_status_reg <= p_status_reg;
            o_rd_reg     <= p_rd_reg;
            o_found_reg  <= p_found_reg;
            o_fpos_reg   <= p_fpos_reg;
            o_count_reg  <= p_count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_BITS'({o_count_reg, o_fpos_reg, o_found_reg, o_rd_reg,
                                     o_status_reg});

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == S_EXEC)
        else $error("accepted transaction did not reach execute");

    a_remove_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && act_reg == ACT_REMOVE && scan_any)
        |=> (count_reg == $past(count_reg) - POS_BITS'(1)) && state_reg == S_RCMP)
        else $error("remove step did not drop one entry");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> m_valid_reg)
        else $error("result held back with output register empty");

endmodule

`default_nettype wire

[hw/rtl/oat_cell.sv]
`default_nettype none

module oat_cell #(
    parameter int DEPTH     = oat_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = oat_pkg::WORD_BITS_DEFAULT,
    parameter int INDEX     = 0,
    localparam int POS_BITS = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  oat_pkg::cell_ctl_t    ctl,
    input  logic [POS_BITS-1:0]   pos,
    input  logic [POS_BITS-1:0]   count,
    input  logic [WORD_BITS-1:0]  cmp_word,
    input  logic [WORD_BITS-1:0]  wr_word,
    input  logic [WORD_BITS-1:0]  left_data,
    input  logic [WORD_BITS-1:0]  right_data,
    output logic [WORD_BITS-1:0]  data,
    output logic                  match
);
    import oat_pkg::*;

    localparam logic [POS_BITS-1:0] CELL_IDX = POS_BITS'(INDEX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 match_reg;
    logic                 match_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (CELL_IDX > pos)
                begin
                    data_next = left_data;
                end
                else if (CELL_IDX == pos)
                begin
                    data_next = wr_word;
                end
            end
            CELL_DELETE:
            begin
                if (CELL_IDX >= pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctl.cmp_en)
        begin
            match_next = (CELL_IDX < count) && (data_reg == cmp_word);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

[hw/rtl/oat_scan.sv]
`default_nettype none

module oat_scan #(
    parameter int DEPTH     = oat_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = oat_pkg::WORD_BITS_DEFAULT,
    localparam int POS_BITS = $clog2(DEPTH + 1),
    localparam int IDX_BITS = $clog2(DEPTH)
) (
    input  logic [DEPTH-1:0]                 match,
    input  logic [DEPTH-1:0][WORD_BITS-1:0]  cell_data,
    input  logic [POS_BITS-1:0]              pos,
    output logic                             any,
    output logic [IDX_BITS-1:0]              first_idx,
    output logic [WORD_BITS-1:0]             rd_word
);
    import oat_pkg::*;

    logic [DEPTH-1:0]     first;
    logic [IDX_BITS-1:0]  idx_acc;
    logic [WORD_BITS-1:0] rd_acc;

    always_comb
    begin
        first   = match & (~match + DEPTH'(1));
        idx_acc = '0;
        rd_acc  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                idx_acc = idx_acc | IDX_BITS'(i);
            end
            if (pos == POS_BITS'(i))
            begin
                rd_acc = rd_acc | cell_data[i];
            end
        end
    end

    assign any       = |match;
    assign first_idx = idx_acc;
    assign rd_word   = rd_acc;

endmodule

`default_nettype wire

[bench/tb_ordered_array_table_engine_core.sv]
module tb_ordered_array_table_engine_core;
    import oat_pkg::*;

    localparam int DEPTH        = 64;
    localparam int S_BITS       = 48;
    localparam int M_BITS       = 48;
    localparam int RANDOM_ITEMS = 850;
    localparam int QUIET_ITEMS  = 80;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 200;

    typedef enum int {
        PH_MIXED,
        PH_FILL,
        PH_DRAIN
    } phase_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] read_value;
        logic        found;
        logic [5:0]  found_position;
        logic [6:0]  entry_count;
    } reply_t;

    typedef struct packed {
        action_t     action;
        logic [6:0]  position;
        logic [31:0] operand;
    } order_t;

    typedef struct packed {
        logic   typed;
        reply_t reply;
    } row_check_t;

    typedef struct packed {
        order_t     ord;
        row_check_t chk;
    } plan_row_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [M_BITS-1:0] m_tdata;

    logic [31:0] shadow_words [DEPTH];
    int          shadow_count = 0;
    reply_t      pending_replies[$];
    row_check_t  row_checks[$];
    plan_row_t   plan[$];
    int          mismatches   = 0;
    int          results_seen = 0;
    bit          quiet        = 1'b0;

    ordered_array_table_engine_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL ordered_array_table_engine_core");
        $finish;
    end

    function automatic reply_t table_apply(order_t o);
        reply_t r;
        int     i;
        int     slot;
        int     keep;
        r = '0;
        case (o.action)
            ACT_APPEND, ACT_INSERT, ACT_PREPEND: begin
                slot = (o.action == ACT_APPEND)  ? shadow_count :
                       (o.action == ACT_PREPEND) ? 0 : int'(o.position);
                if (o.action == ACT_INSERT && o.position > shadow_count)
                    r.status = STAT_RANGE;
                else if (shadow_count >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    for (i = shadow_count; i > slot; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[slot] = o.operand;
                    shadow_count++;
                end
            end
            ACT_POP: begin
                if (shadow_count == 0)
                    r.status = STAT_EMPTY;
                else
                    shadow_count--;
            end
            ACT_DELETE: begin
                if (shadow_count == 0)
                    r.status = STAT_EMPTY;
                else if (o.position >= shadow_count)
                    r.status = STAT_RANGE;
                else
                begin
                    for (i = o.position; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                end
            end
            ACT_REMOVE: begin
                keep = 0;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_words[i] != o.operand)
                    begin
                        shadow_words[keep] = shadow_words[i];
                        keep++;
                    end
                end
                shadow_count = keep;
            end
            ACT_FIND: begin
                for (i = 0; i < shadow_count && !r.found; i++)
                begin
                    if (shadow_words[i] == o.operand)
                    begin
                        r.found          = 1'b1;
                        r.found_position = 6'(i);
                    end
                end
            end
            ACT_READ: begin
                if (o.position >= shadow_count)
                    r.status = STAT_RANGE;
                else
                    r.read_value = shadow_words[o.position];
            end
        endcase
        r.entry_count = 7'(shadow_count);
        return r;
    endfunction

    function automatic string show(reply_t r);
        return $sformatf("status=%0d read=%h found=%0b at=%0d count=%0d",
                         r.status, r.read_value, r.found, r.found_position, r.entry_count);
    endfunction

    always @(posedge clk) begin : scoreboard
        reply_t     got;
        reply_t     want;
        order_t     ord;
        row_check_t rc;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got.status         = status_t'(m_tdata[1:0]);
            got.read_value     = m_tdata[33:2];
            got.found          = m_tdata[34];
            got.found_position = m_tdata[40:35];
            got.entry_count    = m_tdata[47:41];
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %s", show(got));
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.status !== want.status || got.read_value !== want.read_value
                    || got.found !== want.found || got.found_position !== want.found_position
                    || got.entry_count !== want.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %s, got %s", show(want), show(got));
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            ord.action   = action_t'(s_tdata[2:0]);
            ord.position = s_tdata[9:3];
            ord.operand  = s_tdata[41:10];
            want = table_apply(ord);
            rc   = row_checks.pop_front();
            pending_replies.push_back(rc.typed ? rc.reply : want);
        end
    end

    // hold off once for a long stretch so the core backs up into its input
    initial begin : result_stall
        bit held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
                if ($urandom_range(0, 2) != 0)
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge clk);
                end
            end
        end
    end

    task automatic row(action_t a, int pos, logic [31:0] val, bit typed,
                       status_t st = STAT_OK, logic [31:0] rd = '0, bit fnd = 1'b0,
                       int fp = 0, int cnt = 0);
        plan_row_t p;
        p.ord.action                   = a;
        p.ord.position                 = 7'(pos);
        p.ord.operand                  = val;
        p.chk.typed                    = typed;
        p.chk.reply.status             = st;
        p.chk.reply.read_value         = rd;
        p.chk.reply.found              = fnd;
        p.chk.reply.found_position     = 6'(fp);
        p.chk.reply.entry_count        = 7'(cnt);
        plan.push_back(p);
    endtask

    task automatic offer(order_t o, row_check_t rc);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        row_checks.push_back(rc);
        s_tdata  <= {6'd0, o.operand, o.position, o.action};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    function automatic order_t pick_order(phase_t ph);
        order_t o;
        int     roll;
        roll = $urandom_range(0, 9);
        case (ph)
            PH_FILL:
                o.action = (roll < 8) ? action_t'($urandom_range(0, 2))
                                      : action_t'($urandom_range(0, 7));
            PH_DRAIN:
                o.action = (roll < 7) ? action_t'($urandom_range(3, 5))
                                      : action_t'($urandom_range(0, 7));
            default:
                o.action = action_t'($urandom_range(0, 7));
        endcase
        if ($urandom_range(0, 4) != 0)
            o.position = 7'($urandom_range(0, shadow_count));
        else
            o.position = 7'($urandom_range(0, DEPTH));
        roll = $urandom_range(0, 9);
        if (roll < 4 && shadow_count > 0)
            o.operand = shadow_words[$urandom_range(0, shadow_count - 1)];
        else if (roll < 7)
            o.operand = $urandom_range(0, 5);
        else if (roll == 7)
            o.operand = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            o.operand = $urandom;
        return o;
    endfunction

    initial begin : stimulus
        row_check_t none;
        phase_t     ph;
        int         n;
        none = '0;

        row(ACT_POP,     0, 32'd0,         1, STAT_EMPTY);
        row(ACT_DELETE,  0, 32'd0,         1, STAT_EMPTY);
        row(ACT_READ,    0, 32'd0,         1, STAT_RANGE);
        row(ACT_FIND,    0, 32'd5,         1, STAT_OK);
        row(ACT_REMOVE,  0, 32'd5,         1, STAT_OK);
        row(ACT_APPEND,  0, 32'h7FFF_FFFF, 1, STAT_OK,    '0, 0, 0, 1);
        row(ACT_PREPEND, 0, 32'h8000_0000, 1, STAT_OK,    '0, 0, 0, 2);
        row(ACT_INSERT,  3, 32'd1,         1, STAT_RANGE, '0, 0, 0, 2);
        row(ACT_INSERT,  2, 32'hFFFF_FFFF, 1, STAT_OK,    '0, 0, 0, 3);
        row(ACT_INSERT,  1, 32'd0,         0);
        row(ACT_READ,    0, 32'd0,         1, STAT_OK,    32'h8000_0000, 0, 0, 4);
        row(ACT_READ,    3, 32'd0,         1, STAT_OK,    32'hFFFF_FFFF, 0, 0, 4);
        row(ACT_READ,    4, 32'd0,         1, STAT_RANGE, '0, 0, 0, 4);
        row(ACT_READ,   64, 32'd0,         1, STAT_RANGE, '0, 0, 0, 4);
        row(ACT_FIND,    0, 32'hFFFF_FFFF, 1, STAT_OK,    '0, 1, 3, 4);
        row(ACT_DELETE,  4, 32'd0,         1, STAT_RANGE, '0, 0, 0, 4);
        row(ACT_DELETE,  0, 32'd0,         1, STAT_OK,    '0, 0, 0, 3);
        row(ACT_APPEND,  0, 32'd0,         0);
        row(ACT_REMOVE,  0, 32'd0,         1, STAT_OK,    '0, 0, 0, 2);
        row(ACT_FIND,    0, 32'd0,         1, STAT_OK,    '0, 0, 0, 2);
        row(ACT_INSERT, 64, 32'd2,         1, STAT_RANGE, '0, 0, 0, 2);
        row(ACT_POP,     0, 32'd0,         1, STAT_OK,    '0, 0, 0, 1);
        row(ACT_READ,    0, 32'd0,         0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < plan.size(); n++)
            offer(plan[n].ord, plan[n].chk);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ((n / 100) % 4)
                1:       ph = PH_FILL;
                3:       ph = PH_DRAIN;
                default: ph = PH_MIXED;
            endcase
            if (n >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            offer(pick_order(ph), none);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("PASS ordered_array_table_engine_core");
        else
            $display("FAIL ordered_array_table_engine_core");
        $finish;
    end

endmodule
